### rtl/s256h_pkg.sv
// Package: constants, types and functions shared by the hasher modules
`timescale 1ns / 1ps
package s256h_pkg;

   localparam int unsigned BlockWords = 16;
   localparam int unsigned Rounds     = 64;
   localparam logic [7:0]  PadByte    = 8'h80;

   localparam logic [0:0] OpAbsorb = 1'b0;
   localparam logic [0:0] OpFinish = 1'b1;

   typedef logic [31:0] word_type;

   // datapath commands from the controller
   typedef struct packed {
      logic       load_byte;    // write byte into the block buffer
      logic       pad_byte;     // write 0x80 at current position
      logic       zero_fill;    // write zero word
      logic       len_hi;       // write upper length word at word 14
      logic       len_lo;       // write lower length word at word 15
      logic [3:0] fill_word;    // word index for fill/length writes
      logic       count_byte;   // bump the bit count
      logic       init_rounds;  // copy chaining value into a..h
      logic       do_round;     // one compression round
      logic [5:0] round;        // round number
      logic       fold;         // add a..h into chaining value
      logic       restart;      // reload initial hash, clear count
      logic       emit_shift;   // move to next digest word
      logic       latch_len;    // hold message length for padding
   } cmd_type;

   typedef struct packed {
      logic [5:0] pos;          // byte position in block
   } sts_type;

   function automatic word_type init_hash(input logic [2:0] idx);
      word_type v;
      case (idx)
         3'd0:    v = 32'h6a09e667;
         3'd1:    v = 32'hbb67ae85;
         3'd2:    v = 32'h3c6ef372;
         3'd3:    v = 32'ha54ff53a;
         3'd4:    v = 32'h510e527f;
         3'd5:    v = 32'h9b05688c;
         3'd6:    v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   localparam word_type RoundK [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

### rtl/s256h_ifs.sv
// Interfaces: request and response channels
`timescale 1ns / 1ps
interface s256h_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;
   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface s256h_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last;
   modport source (output valid, output digest_word, output word_index, output last,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last,
                   output ready);
endinterface

### rtl/s256h_datapath.sv
// Datapath: block buffer, schedule, round variables, chaining value, bit count
`timescale 1ns / 1ps
module s256h_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  s256h_pkg::cmd_type   cmd,
   input  logic [7:0]           data_byte,
   output s256h_pkg::sts_type   sts,
   output logic [31:0]          digest_word
);
   s256h_pkg::word_type blk_ff [16];
   s256h_pkg::word_type blk_in [16];
   s256h_pkg::word_type rv_ff [8];
   s256h_pkg::word_type rv_in [8];
   s256h_pkg::word_type cv_ff [8];
   s256h_pkg::word_type cv_in [8];
   logic [63:0] bits_ff, bits_in;
   logic [63:0] len_ff, len_in;

   logic [5:0] pos;
   logic [3:0] wsel;
   logic [1:0] bsel;
   s256h_pkg::word_type w, s0, s1, x15, x2, t1, t2, ch, mj, cur;

   assign pos  = bits_ff[8:3];
   assign wsel = pos[5:2];
   assign bsel = pos[1:0];
   assign sts.pos = pos;
   assign digest_word = cv_ff[0];

   function automatic s256h_pkg::word_type ror(input s256h_pkg::word_type v,
                                               input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   always_comb begin
      // schedule window lives in the block buffer itself
      x15 = blk_ff[1];
      x2  = blk_ff[14];
      s0  = ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3);
      s1  = ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10);
      w   = (cmd.round < 6'd16) ? blk_ff[0] : blk_ff[0] + s0 + blk_ff[9] + s1;
      t1  = rv_ff[7] + (ror(rv_ff[4], 6) ^ ror(rv_ff[4], 11) ^ ror(rv_ff[4], 25))
          + ((rv_ff[4] & rv_ff[5]) ^ (~rv_ff[4] & rv_ff[6]))
          + s256h_pkg::RoundK[cmd.round] + w;
      ch  = ror(rv_ff[0], 2) ^ ror(rv_ff[0], 13) ^ ror(rv_ff[0], 22);
      mj  = (rv_ff[0] & rv_ff[1]) ^ (rv_ff[0] & rv_ff[2]) ^ (rv_ff[1] & rv_ff[2]);
      t2  = ch + mj;

      blk_in  = blk_ff;
      rv_in   = rv_ff;
      cv_in   = cv_ff;
      bits_in = bits_ff;
      len_in  = len_ff;
      cur     = blk_ff[wsel];

      if (cmd.load_byte || cmd.pad_byte) begin
         case (bsel)
            2'd0:    cur[31:24] = cmd.pad_byte ? s256h_pkg::PadByte : data_byte;
            2'd1:    cur[23:16] = cmd.pad_byte ? s256h_pkg::PadByte : data_byte;
            2'd2:    cur[15:8]  = cmd.pad_byte ? s256h_pkg::PadByte : data_byte;
            default: cur[7:0]   = cmd.pad_byte ? s256h_pkg::PadByte : data_byte;
         endcase
         // clear the bytes after the pad within the word
         if (cmd.pad_byte) begin
            case (bsel)
               2'd0:    cur[23:0] = '0;
               2'd1:    cur[15:0] = '0;
               2'd2:    cur[7:0]  = '0;
               default: cur      = cur;
            endcase
         end
         blk_in[wsel] = cur;
      end
      if (cmd.zero_fill) blk_in[cmd.fill_word] = '0;
      if (cmd.len_hi)    blk_in[cmd.fill_word] = len_ff[63:32];
      if (cmd.len_lo)    blk_in[cmd.fill_word] = len_ff[31:0];
      if (cmd.count_byte) bits_in = bits_ff + 64'd8;
      if (cmd.latch_len)  len_in = bits_ff;

      if (cmd.init_rounds) rv_in = cv_ff;
      if (cmd.do_round) begin
         for (int i = 0; i < 15; i++) blk_in[i] = blk_ff[i + 1];
         blk_in[15] = w;
         rv_in[7] = rv_ff[6];
         rv_in[6] = rv_ff[5];
         rv_in[5] = rv_ff[4];
         rv_in[4] = rv_ff[3] + t1;
         rv_in[3] = rv_ff[2];
         rv_in[2] = rv_ff[1];
         rv_in[1] = rv_ff[0];
         rv_in[0] = t1 + t2;
      end
      if (cmd.fold)
         for (int i = 0; i < 8; i++) cv_in[i] = cv_ff[i] + rv_ff[i];
      if (cmd.emit_shift) begin
         for (int i = 0; i < 7; i++) cv_in[i] = cv_ff[i + 1];
         cv_in[7] = cv_ff[0];
      end
      if (cmd.restart) begin
         for (int i = 0; i < 8; i++) cv_in[i] = s256h_pkg::init_hash(3'(i));
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      rv_ff  <= rv_in;
      len_ff <= len_in;
      if (reset) begin
         for (int i = 0; i < 8; i++) cv_ff[i] <= s256h_pkg::init_hash(3'(i));
         bits_ff <= '0;
      end else begin
         cv_ff   <= cv_in;
         bits_ff <= bits_in;
      end
   end
endmodule

### rtl/s256h_ctrl.sv
// Controller: sequences absorb, padding, compression and digest output
`timescale 1ns / 1ps
module s256h_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   s256h_req_if.sink            req,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_index,
   input  s256h_pkg::sts_type   sts,
   output s256h_pkg::cmd_type   cmd
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_INIT  = 7'b0000010,
      ST_ROUND = 7'b0000100,
      ST_FOLD  = 7'b0001000,
      ST_FILL  = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_PAD   = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       fin_ff, fin_in;     // finishing the message
   logic       extra_ff, extra_in; // current block is the overflow pad block
   logic       acc;

   assign req.ready = (state_ff == ST_IDLE);
   assign acc       = req.valid && req.ready;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_index = cnt_ff[2:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      extra_in = extra_ff;
      cmd      = '0;
      cmd.round     = cnt_ff;
      cmd.fill_word = cnt_ff[3:0];
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req.op == s256h_pkg::OpAbsorb) begin
                  cmd.load_byte  = 1'b1;
                  cmd.count_byte = 1'b1;
                  fin_in = 1'b0;
                  if (sts.pos == 6'd63) state_in = ST_INIT;
               end else begin
                  cmd.pad_byte  = 1'b1;
                  cmd.latch_len = 1'b1;
                  fin_in   = 1'b1;
                  extra_in = (sts.pos >= 6'd56);
                  cnt_in   = {2'b00, sts.pos[5:2] + 4'd1};
                  state_in = (sts.pos[5:2] == 4'd15) ? ST_INIT : ST_FILL;
               end
            end
         end
         ST_FILL: begin
            // zero words up to 13 (or 15 on overflow block), then length
            if (!extra_ff && cnt_ff[3:0] == 4'd14)      cmd.len_hi = 1'b1;
            else if (!extra_ff && cnt_ff[3:0] == 4'd15) cmd.len_lo = 1'b1;
            else                                        cmd.zero_fill = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[3:0] == 4'd15) state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init_rounds = 1'b1;
            cnt_in   = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            cnt_in   = '0;
            if (!fin_ff)       state_in = ST_IDLE;
            else if (extra_ff) state_in = ST_PAD;
            else               state_in = ST_EMIT;
         end
         ST_PAD: begin
            extra_in = 1'b0;
            state_in = ST_FILL;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               cmd.emit_shift = 1'b1;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff[2:0] == 3'd7) begin
                  cmd.restart = 1'b1;
                  fin_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
         extra_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
         extra_ff <= extra_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_only_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> fin_ff) else $error("digest without finish");
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && cnt_ff == 6'd63) |=> state_ff == ST_FOLD)
      else $error("round count overrun");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_index))
      else $error("digest beat dropped");
`endif
endmodule

### rtl/sha256_byte_stream_hasher.sv
// Top level: SHA-256 byte-stream hasher
// Absorb beat: the 64th byte of a block starts compression (init, rounds, fold into the hash).
// Finish beat: pad byte, zero fill and length words, then compression; on overflow the length
// goes in a second zero-filled block, compressed too; then eight digest beats, one per cycle with ready.
// The single shared round unit sets the rate: one round per cycle.
// Synchronous reset loads the initial hash and clears the bit count.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
   input logic          clock,
   input logic          reset,
   s256h_req_if.sink    req,
   s256h_rsp_if.source  rsp
);
   s256h_pkg::cmd_type cmd;
   s256h_pkg::sts_type sts;
   logic [2:0] idx;

   s256h_ctrl u_ctrl (
      .clock, .reset, .req,
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .rsp_index (idx),
      .sts, .cmd
   );

   s256h_datapath u_dp (
      .clock, .reset, .cmd,
      .data_byte   (req.data_byte),
      .sts,
      .digest_word (rsp.digest_word)
   );

   assign rsp.word_index = idx;
   assign rsp.last       = (idx == 3'd7);
endmodule

### tb/tb.sv
// Testbench: byte-stream SHA-256 hasher checked beat by beat against a behavioural digest model
`timescale 1ns / 1ps
module tb;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } digest_beat_type;

   typedef struct {
      req_beat_type beat;
      logic         known;
      logic [31:0]  word0;
   } directed_row_type;

   logic clock;
   logic reset;

   s256h_req_if req ();
   s256h_rsp_if rsp ();

   sha256_byte_stream_hasher dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // predictor state
   logic [31:0] hash_state [8];
   logic [63:0] msg_len_bits;
   logic [7:0]  block_buf [64];

   digest_beat_type digest_queue [$];
   logic [31:0]     word0_queue [$];
   logic            word0_known [$];

   int unsigned mismatches = 0;
   int unsigned beats_sent;
   int unsigned beats_checked = 0;
   int unsigned digests_seen = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   logic        failed;

   function automatic logic [31:0] ror(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic compress_buf();
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int r = 0; r < 64; r++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
            + s256h_pkg::RoundK[r] + w[r];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++)
         hash_state[i] = s256h_pkg::init_hash(3'(i));
      msg_len_bits = '0;
   endtask

   task automatic hash_beat(input req_beat_type b, input logic known, input logic [31:0] w0);
      int unsigned pos;
      logic [63:0] len;
      digest_beat_type d;
      pos = 32'(msg_len_bits[8:3]);
      if (b.op == s256h_pkg::OpAbsorb) begin
         block_buf[pos] = b.data_byte;
         msg_len_bits += 64'd8;
         if (pos == 63) compress_buf();
      end else begin
         len = msg_len_bits;
         block_buf[pos] = s256h_pkg::PadByte;
         pos = pos + 1;
         if (pos > 56) begin
            while (pos < 64) begin
               block_buf[pos] = 8'h00;
               pos = pos + 1;
            end
            compress_buf();
            pos = 0;
         end
         while (pos < 56) begin
            block_buf[pos] = 8'h00;
            pos = pos + 1;
         end
         for (int k = 0; k < 8; k++) block_buf[56+k] = len[63-8*k -: 8];
         compress_buf();
         for (int k = 0; k < 8; k++) begin
            d.digest_word = hash_state[k];
            d.word_index  = 3'(k);
            d.last        = (k == 7);
            digest_queue.push_back(d);
            word0_known.push_back(known && k == 0);
            word0_queue.push_back(w0);
         end
         restart_message();
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: stall and check
   always @(posedge clock) begin
      digest_beat_type got, want;
      logic kn;
      logic [31:0] w0;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp.valid && rsp.ready) begin
            got = {rsp.digest_word, rsp.word_index, rsp.last};
            beats_checked++;
            if (got.last) digests_seen++;
            if (digest_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected digest beat %h idx %0d last %b",
                           got.digest_word, got.word_index, got.last);
            end else begin
               want = digest_queue.pop_front();
               kn = word0_known.pop_front();
               w0 = word0_queue.pop_front();
               if (got !== want || (kn && got.digest_word !== w0)) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                              kn ? w0 : want.digest_word, want.word_index, want.last,
                              got.digest_word, got.word_index, got.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("timeout: %0d digest beats outstanding", digest_queue.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_beat(input req_beat_type b, input logic known, input logic [31:0] w0);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.op        <= b.op;
      req.data_byte <= b.data_byte;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      hash_beat(b, known, w0);
      beats_sent++;
   endtask

   task automatic send_message(input int unsigned len, input logic pattern);
      req_beat_type b;
      for (int i = 0; i < len; i++) begin
         b.op = s256h_pkg::OpAbsorb;
         b.data_byte = pattern ? 8'($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
         send_beat(b, 1'b0, '0);
      end
      b.op = s256h_pkg::OpFinish;
      b.data_byte = 8'($urandom);
      send_beat(b, 1'b0, '0);
   endtask

   directed_row_type directed [$];

   initial begin
      int unsigned len;
      int unsigned blen;
      logic        pat;
      req_beat_type fin;
      reset = 1'b1;
      req.valid = 1'b0;
      req.op = s256h_pkg::OpAbsorb;
      req.data_byte = 8'h00;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      beats_sent = 0;
      restart_message();
      for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty message, finish with data byte set, "abc", extremes
      directed.push_back('{'{s256h_pkg::OpFinish, 8'h00}, 1'b1, 32'he3b0c442});
      directed.push_back('{'{s256h_pkg::OpFinish, 8'hff}, 1'b1, 32'he3b0c442});
      directed.push_back('{'{s256h_pkg::OpAbsorb, 8'h61}, 1'b0, '0});
      directed.push_back('{'{s256h_pkg::OpAbsorb, 8'h62}, 1'b0, '0});
      directed.push_back('{'{s256h_pkg::OpAbsorb, 8'h63}, 1'b0, '0});
      directed.push_back('{'{s256h_pkg::OpFinish, 8'h55}, 1'b1, 32'hba7816bf});
      directed.push_back('{'{s256h_pkg::OpAbsorb, 8'h00}, 1'b0, '0});
      directed.push_back('{'{s256h_pkg::OpFinish, 8'haa}, 1'b0, '0});
      directed.push_back('{'{s256h_pkg::OpAbsorb, 8'hff}, 1'b0, '0});
      directed.push_back('{'{s256h_pkg::OpAbsorb, 8'h00}, 1'b0, '0});
      directed.push_back('{'{s256h_pkg::OpFinish, 8'h00}, 1'b0, '0});
      foreach (directed[i]) send_beat(directed[i].beat, directed[i].known, directed[i].word0);

      // each phase carries one padding boundary message (55, 56, 63, 64 bytes)
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  blen = 55; pat = 1'b1; end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  blen = 56; pat = 1'b0; end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; blen = 63; pat = 1'b0; end
            default: begin
               send_idle_pct = 36; recv_stall_pct = 36; blen = 64; pat = 1'b1;
            end
         endcase
         send_message(blen, pat);
         for (int m = 0; m < 4; m++) begin
            len = $urandom_range(4);
            send_message(len, 1'b0);
         end
         if ($urandom_range(1)) begin
            fin.op = s256h_pkg::OpFinish;
            fin.data_byte = 8'($urandom);
            send_beat(fin, 1'b0, '0);
         end
      end
      req.valid <= 1'b0;

      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("sent %0d request beats, checked %0d digest beats over %0d digests",
               beats_sent, beats_checked, digests_seen);
      $display("covered empty, padding boundary and multi-block messages; %0d mismatches",
               mismatches);
      failed = (mismatches != 0) || (digest_queue.size() != 0);
      if (!failed)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
